### hw/rtl/tss_pkg.sv
// Shared types, widths and constants for the Taylor-series sine block.
// Used by tss_mul and taylor_sine_series; depends on nothing else.
`timescale 1ns / 1ps

package tss_pkg;

  localparam int MAX_TERMS  = 16;
  localparam int FRAC_BITS  = 28;
  localparam int RECIP_BITS = 40;

  localparam int X_W    = 32;               // input angle, Q3.28
  localparam int OUT_W  = 34;               // result, Q5.28
  localparam int MAG_W  = 56;               // term magnitude, capped at 2^56-1
  localparam int OPB_W  = 38;               // second multiplier operand (xsq or reciprocal)
  localparam int PROD_W = MAG_W + OPB_W;    // full product
  localparam int ACC_W  = 62;               // signed sum of up to MAX_TERMS magnitudes
  localparam int CNT_W  = $clog2(MAX_TERMS + 1);
  localparam int IDX_W  = $clog2(MAX_TERMS);
  localparam int CFG_W  = 5;

  localparam logic [CFG_W-1:0] NUM_TERMS_RST = CFG_W'(10);
  localparam logic [CNT_W-1:0] TERM_CAP      = CNT_W'(MAX_TERMS);

  localparam logic [MAG_W-1:0] MAG_CAP = {MAG_W{1'b1}};

  localparam logic signed [ACC_W-1:0] OUT_MAX = ACC_W'((64'sd1 <<< (OUT_W - 1)) - 64'sd1);
  localparam logic signed [ACC_W-1:0] OUT_MIN = -OUT_MAX - ACC_W'(1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_MUL_X,
    ST_MUL_R,
    ST_DONE
  } tss_state_t;

  // Request to the shared multiply-and-shift unit.
  typedef struct packed {
    logic             start;
    logic             long_shift;   // 1: shift by RECIP_BITS, 0: by FRAC_BITS
    logic [MAG_W-1:0] a;
    logic [OPB_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic             done;
    logic [MAG_W-1:0] result;
  } mul_rsp_t;

  // Rounded reciprocal of (2i)(2i+1), scaled by 2^RECIP_BITS.
  function automatic logic [OPB_W-1:0] recip(input logic [IDX_W-1:0] i);
    logic [OPB_W-1:0] r;
    unique case (i)
      4'd1:    r = 38'd183251937963;
      4'd2:    r = 38'd54975581389;
      4'd3:    r = 38'd26178848280;
      4'd4:    r = 38'd15270994830;
      4'd5:    r = 38'd9995560253;
      4'd6:    r = 38'd7048151460;
      4'd7:    r = 38'd5235769656;
      4'd8:    r = 38'd4042322161;
      4'd9:    r = 38'd3214946280;
      4'd10:   r = 38'd2617884828;
      4'd11:   r = 38'd2172947881;
      4'd12:   r = 38'd1832519380;
      4'd13:   r = 38'd1566255880;
      4'd14:   r = 38'd1354078359;
      4'd15:   r = 38'd1182270568;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

### hw/rtl/tss_mul.sv
// Iterative multiply-and-shift unit: (a * b) >> 28 or 40, capped at 2^56-1.
// One 32x32 partial product per cycle; depends on tss_pkg.
`timescale 1ns / 1ps

module tss_mul import tss_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  mul_req_t req,
  output mul_rsp_t rsp
);

  localparam logic [2:0] LAST_PP   = 3'd3;
  localparam logic [2:0] LAST_STEP = 3'd5;

  logic              busy;
  logic              done;
  logic [2:0]        step;
  logic [MAG_W-1:0]  a_op;
  logic [OPB_W-1:0]  b_op;
  logic              long_sh;
  logic [63:0]       pp;
  logic [1:0]        pp_pos;
  logic [PROD_W-1:0] prod;
  logic [MAG_W-1:0]  result;

  logic [31:0]       a_sel;
  logic [31:0]       b_sel;
  logic [PROD_W-1:0] pp_aligned;
  logic [PROD_W-1:0] prod_shr;
  logic [MAG_W-1:0]  clipped;

  // Limb order: a0*b0, a0*b1, a1*b0, a1*b1.
  assign a_sel = step[1] ? 32'(a_op[MAG_W-1:32]) : a_op[31:0];
  assign b_sel = step[0] ? 32'(b_op[OPB_W-1:32]) : b_op[31:0];

  always_comb begin
    case (pp_pos)
      2'd0:    pp_aligned = PROD_W'(pp);
      2'd1:    pp_aligned = PROD_W'(pp) << 32;
      default: pp_aligned = PROD_W'(pp) << 64;
    endcase
  end

  assign prod_shr = long_sh ? (prod >> RECIP_BITS) : (prod >> FRAC_BITS);
  assign clipped  = (|prod_shr[PROD_W-1:MAG_W]) ? MAG_CAP : prod_shr[MAG_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 3'd1;
        if (step == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a_op    <= req.a;
      b_op    <= req.b;
      long_sh <= req.long_shift;
      prod    <= '0;
    end else if (busy) begin
      if (step <= LAST_PP) begin
        pp     <= 64'(a_sel) * 64'(b_sel);
        pp_pos <= {1'b0, step[1]} + {1'b0, step[0]};
      end
      if (step != 3'd0 && step != LAST_STEP) begin
        prod <= prod + pp_aligned;
      end
      if (step == LAST_STEP) begin
        result <= clipped;
      end
    end
  end

  assign rsp.done   = done;
  assign rsp.result = result;

endmodule

### hw/rtl/taylor_sine_series.sv
// Truncated Taylor-series sine, fixed point, top level.
// Depends on tss_pkg and tss_mul.
`timescale 1ns / 1ps

// Usage:
//   cfg channel (cfg_valid/cfg_ready/cfg_data): writes num_terms, the number of
//   series terms (0..31, counts above 16 sum 16 terms, zero gives 0). Write it
//   only while the block is idle. Reset value is 10.
//   in channel (in_valid/in_stall/x_angle): one signed Q3.28 angle per transfer.
//   out channel (out_valid/out_stall/sine_value/saturated): one Q5.28 sum per
//   angle, clipped to the 34-bit range with saturated set when clipped.
// Timing: all multiplies run on one shared 32x32 multiplier in tss_mul, four
//   partial products per multiply. Each term after the first needs two
//   multiplies (by x^2, then by the reciprocal of the factorial step), and x^2
//   itself needs one; with zero terms no multiply runs. One item is worked on
//   at a time; in_stall is high from accept until the result is loaded, so the
//   next angle can transfer once the block is idle again.
// Receiver stall: the result sits in an output register; a new angle is taken
//   as soon as the result is loaded, even if out_stall holds it. A finished
//   result waits in the done state until the output register is free.
// Reset (rst, synchronous): drops any item in flight, empties the output
//   register and restores num_terms to 10.

module taylor_sine_series import tss_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  // configuration write channel
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_W-1:0]        cfg_data,
  // angle input channel
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [X_W-1:0]   x_angle,
  // result output channel
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [OUT_W-1:0] sine_value,
  output logic                    saturated
);

  tss_state_t state, state_next;

  logic [CFG_W-1:0]        num_terms;
  logic                    neg;
  logic [MAG_W-1:0]        mag;
  logic [OPB_W-1:0]        xsq;
  logic signed [ACC_W-1:0] acc;
  logic [CNT_W-1:0]        term_idx;
  logic [CNT_W-1:0]        term_cnt;

  mul_req_t mul_req;
  mul_rsp_t mul_rsp;

  logic                    in_xfer;
  logic                    out_free;
  logic [X_W-1:0]          x_mag;
  logic [CNT_W-1:0]        cnt_in;
  logic [CNT_W-1:0]        term_idx_next;
  logic                    minus;
  logic signed [ACC_W-1:0] term_val;
  logic signed [ACC_W-1:0] acc_upd;

  assign in_stall  = (state != ST_IDLE);
  assign cfg_ready = (state == ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // Magnitude of the angle; the most negative code maps to 2^31 on its own.
  assign x_mag  = x_angle[X_W-1] ? (~x_angle + X_W'(1)) : x_angle;
  assign cnt_in = (CNT_W'(num_terms) > TERM_CAP) ? TERM_CAP : CNT_W'(num_terms);

  assign term_idx_next = term_idx + CNT_W'(1);

  // Term sign alternates, starting from the sign of x.
  assign minus    = neg ^ term_idx[0];
  assign term_val = minus ? -$signed(ACC_W'(mul_rsp.result)) : $signed(ACC_W'(mul_rsp.result));
  assign acc_upd  = acc + term_val;

  tss_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mul_req),
    .rsp (mul_rsp)
  );

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      num_terms <= NUM_TERMS_RST;
    end else if (cfg_valid && cfg_ready) begin
      num_terms <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer: next state and requests to the shared multiplier.
  always_comb begin
    state_next         = state;
    mul_req.start      = 1'b0;
    mul_req.long_shift = 1'b0;
    mul_req.a          = mag;
    mul_req.b          = xsq;
    unique case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          if (cnt_in == '0) begin
            state_next = ST_DONE;
          end else begin
            // square the angle magnitude
            state_next    = ST_SQUARE;
            mul_req.start = 1'b1;
            mul_req.a     = MAG_W'(x_mag);
            mul_req.b     = OPB_W'(x_mag);
          end
        end
      end
      ST_SQUARE: begin
        if (mul_rsp.done) begin
          if (term_cnt == CNT_W'(1)) begin
            state_next = ST_DONE;
          end else begin
            state_next    = ST_MUL_X;
            mul_req.start = 1'b1;
            mul_req.a     = mag;
            mul_req.b     = mul_rsp.result[OPB_W-1:0];
          end
        end
      end
      ST_MUL_X: begin
        if (mul_rsp.done) begin
          state_next         = ST_MUL_R;
          mul_req.start      = 1'b1;
          mul_req.long_shift = 1'b1;
          mul_req.a          = mul_rsp.result;
          mul_req.b          = recip(term_idx[IDX_W-1:0]);
        end
      end
      ST_MUL_R: begin
        if (mul_rsp.done) begin
          if (term_idx_next == term_cnt) begin
            state_next = ST_DONE;
          end else begin
            state_next    = ST_MUL_X;
            mul_req.start = 1'b1;
            mul_req.a     = mul_rsp.result;
            mul_req.b     = xsq;
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Datapath: term magnitude, x^2, accumulator and term count.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          neg      <= x_angle[X_W-1];
          mag      <= MAG_W'(x_mag);
          term_cnt <= cnt_in;
          term_idx <= '0;
          acc      <= '0;
        end
      end
      ST_SQUARE: begin
        if (mul_rsp.done) begin
          // hold x^2 and add the first term, x itself
          xsq      <= mul_rsp.result[OPB_W-1:0];
          acc      <= neg ? -$signed(ACC_W'(mag)) : $signed(ACC_W'(mag));
          term_idx <= CNT_W'(1);
        end
      end
      ST_MUL_R: begin
        if (mul_rsp.done) begin
          mag      <= mul_rsp.result;
          acc      <= acc_upd;
          term_idx <= term_idx_next;
        end
      end
      default: begin
      end
    endcase
  end

  // Output register with saturation to Q5.28.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      if (acc > OUT_MAX) begin
        sine_value <= OUT_W'(OUT_MAX);
        saturated  <= 1'b1;
      end else if (acc < OUT_MIN) begin
        sine_value <= OUT_W'(OUT_MIN);
        saturated  <= 1'b1;
      end else begin
        sine_value <= OUT_W'(acc);
        saturated  <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  // The multiplier only reports back while a term is being worked on.
  a_mul_done_busy: assert property (@(posedge clk) disable iff (rst)
    mul_rsp.done |-> (state == ST_SQUARE || state == ST_MUL_X || state == ST_MUL_R))
    else $error("multiplier done outside a working state");

  // Term index stays between the first and the last configured term.
  a_term_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MUL_X || state == ST_MUL_R) |->
      (term_idx != '0 && term_idx < term_cnt && term_cnt <= TERM_CAP))
    else $error("term index out of range");

  // A clipped result sits at one end of the output range.
  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    (out_valid && saturated) |->
      (sine_value == OUT_W'(OUT_MAX) || sine_value == OUT_W'(OUT_MIN)))
    else $error("saturated flag without a range-end value");

  // An accepted angle always starts work.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> (state != ST_IDLE))
    else $error("accepted angle did not start work");
`endif

endmodule

### test/tb_taylor_sine_series.sv
// Self-checking testbench for taylor_sine_series: random and directed angles
// under several term counts, checked against an in-bench fixed-point series.
// Depends on tss_pkg and the taylor_sine_series RTL only.
`timescale 1ns / 1ps

module tb_taylor_sine_series;
  import tss_pkg::*;

  // Cycles with no transfer on any channel before the run is declared hung.
  // The slowest item, the longest sender gap and the longest receiver stall
  // all stay far below it, so this is several times the worst correct wait.
  localparam int HANG_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 250;

  localparam logic [63:0] MAG_LIMIT = (64'd1 << 56) - 64'd1;
  localparam longint SINE_MAX = (64'sd1 <<< (OUT_W - 1)) - 64'sd1;
  localparam longint SINE_MIN = -SINE_MAX - 64'sd1;

  // A few angles in Q3.28.
  localparam int ONE_Q = 268435456;
  localparam int HALF_PI_Q = 421657428;
  localparam int PI_Q = 843314857;
  localparam int TWO_PI_Q = 1686629713;

  typedef struct {
    logic signed [OUT_W-1:0] value;
    logic                    clip;
  } sine_result_t;

  logic                    clk;
  logic                    rst = 1'b1;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_W-1:0]        cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic signed [X_W-1:0]   x_angle = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [OUT_W-1:0] sine_value;
  logic                    saturated;

  logic signed [X_W-1:0] pending_angles[$];
  sine_result_t          sine_expected[$];
  logic [CFG_W-1:0]      terms_setting = NUM_TERMS_RST;
  int                    mismatch_count = 0;
  bit                    quiet = 1'b0;    // no idling on either side
  bit                    angle_taken = 1'b0;

  taylor_sine_series u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .x_angle    (x_angle),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .sine_value (sine_value),
    .saturated  (saturated)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Series predictor
  // ---------------------------------------------------------------------------

  // (a * b) >> sh on unsigned magnitudes, held at the 56-bit term cap.
  function automatic logic [63:0] scaled_product(input logic [63:0] a, input logic [63:0] b,
                                                 input int sh);
    logic [127:0] p;
    p = 128'(a) * 128'(b);
    p = p >> sh;
    return (p > 128'(MAG_LIMIT)) ? MAG_LIMIT : p[63:0];
  endfunction

  // Rounded 2^RECIP_BITS / ((2i)(2i+1)), the factor that turns x^(2i-1)/(2i-1)!
  // times x^2 into x^(2i+1)/(2i+1)!.
  function automatic logic [63:0] factorial_step_recip(input int i);
    logic [63:0] d;
    d = 64'(2 * i) * 64'(2 * i + 1);
    return ((64'd1 << RECIP_BITS) + d / 64'd2) / d;
  endfunction

  function automatic sine_result_t sine_series(input logic [X_W-1:0] x,
                                               input logic [CFG_W-1:0] n);
    sine_result_t r;
    logic [63:0]  mag;
    logic [63:0]  xsq;
    longint       acc;
    int           cnt;
    bit           neg;
    neg = x[X_W-1];
    // The most negative angle has magnitude 2^31, which still fits 32 bits.
    mag = {32'd0, neg ? (~x + 32'd1) : x};
    xsq = scaled_product(mag, mag, FRAC_BITS);
    cnt = (int'(n) > MAX_TERMS) ? MAX_TERMS : int'(n);
    acc = 0;
    for (int i = 0; i < cnt; i++) begin
      if (i > 0) begin
        mag = scaled_product(mag, xsq, FRAC_BITS);
        mag = scaled_product(mag, factorial_step_recip(i), RECIP_BITS);
      end
      // Terms alternate in sign, the first one carrying the sign of x.
      if (neg != (i % 2 == 1)) acc -= $signed(mag);
      else acc += $signed(mag);
    end
    r.clip = 1'b0;
    if (acc > SINE_MAX) begin
      acc = SINE_MAX;
      r.clip = 1'b1;
    end else if (acc < SINE_MIN) begin
      acc = SINE_MIN;
      r.clip = 1'b1;
    end
    r.value = OUT_W'(acc);
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Angle driver: bursts of transfers with random gaps between them
  // ---------------------------------------------------------------------------

  int burst_left = 0;
  int gap_left = 0;

  always @(negedge clk) begin
    logic next_valid;
    next_valid = in_valid;
    if (!in_valid || angle_taken) begin
      angle_taken = 1'b0;
      next_valid = 1'b0;
      if (gap_left > 0 && !quiet) begin
        gap_left--;
      end else if (pending_angles.size() > 0) begin
        x_angle <= pending_angles.pop_front();
        next_valid = 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          // Mostly short gaps; now and then one long enough to land after the
          // result is loaded, or while it waits on the receiver.
          burst_left = $urandom_range(0, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 250)
                                                 : $urandom_range(0, 6);
        end
      end
    end
    in_valid <= next_valid;
  end

  // ---------------------------------------------------------------------------
  // Receiver stall pattern: runs of ready and runs of stall
  // ---------------------------------------------------------------------------

  int stall_left = 0;
  int run_left = 0;

  always @(negedge clk) begin
    if (quiet) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (run_left > 0) begin
      run_left--;
      out_stall <= 1'b0;
    end else begin
      stall_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 300)
                                               : $urandom_range(0, 12);
      run_left = $urandom_range(0, 40);
      out_stall <= (stall_left > 0);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on each angle transfer, check each result transfer
  // ---------------------------------------------------------------------------

  int idle_cycles = 0;

  always @(posedge clk) begin
    sine_result_t want;
    bit           in_fire;
    bit           out_fire;
    bit           cfg_fire;
    in_fire = !rst && in_valid && !in_stall;
    out_fire = !rst && out_valid && !out_stall;
    cfg_fire = !rst && cfg_valid && cfg_ready;

    if (in_fire) begin
      sine_expected.push_back(sine_series(x_angle, terms_setting));
      angle_taken = 1'b1;
    end

    if (out_fire) begin
      if (sine_expected.size() == 0) begin
        report_mismatch($sformatf("result %0d with no angle outstanding", sine_value));
      end else begin
        want = sine_expected.pop_front();
        if (sine_value !== want.value)
          report_mismatch($sformatf("sine_value %0d, expected %0d", sine_value, want.value));
        if (saturated !== want.clip)
          report_mismatch($sformatf("saturated %b, expected %b", saturated, want.clip));
      end
    end

    // Hang detection: count cycles in which nothing moves on any channel.
    if (rst || in_fire || out_fire || cfg_fire) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= HANG_LIMIT) begin
      $display("%0t ns: no transfer for %0d cycles", $time, HANG_LIMIT);
      $display("tb_taylor_sine_series failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  function automatic logic signed [X_W-1:0] pick_angle();
    int k;
    case ($urandom_range(0, 9)) inside
      [0:4]: return $urandom();
      [5:6]: return $signed($urandom_range(0, 2 * ONE_Q)) - ONE_Q;
      7: begin
        // near a multiple of pi/2, where the sum crosses zero or peaks
        k = $signed($urandom_range(0, 8)) - 4;
        return k * HALF_PI_Q + $signed($urandom_range(0, 2000)) - 1000;
      end
      8: begin
        if ($urandom_range(0, 1) == 1) return 32'h7FFF_FFFF - $urandom_range(0, 255);
        else return 32'h8000_0000 + $urandom_range(0, 255);
      end
      default: return $signed($urandom_range(0, 16)) - 8;
    endcase
  endfunction

  // Write the term count; the block must be idle.
  task automatic write_terms(input logic [CFG_W-1:0] n);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= n;
    do @(posedge clk); while (!cfg_ready);
    terms_setting = n;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Hold the sender until every queued angle is sent and every result is in.
  task automatic drain();
    while (pending_angles.size() != 0 || in_valid || sine_expected.size() != 0)
      @(negedge clk);
  endtask

  task automatic run_phase(input int n, input bit write, input int count,
                           input bit no_idle);
    if (write) write_terms(CFG_W'(n));
    quiet = no_idle;
    // Range ends and zero under every setting.
    pending_angles.push_back(32'sh0000_0000);
    pending_angles.push_back(32'sh7FFF_FFFF);
    pending_angles.push_back(32'sh8000_0000);
    repeat (count) pending_angles.push_back(pick_angle());
    drain();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed angles at the reset term count: unit steps, range ends,
    // multiples of pi/2, alternating bit patterns.
    pending_angles = '{32'sd1, -32'sd1, 32'sh7FFF_FFFF, 32'sh8000_0000,
                       ONE_Q, -ONE_Q, ONE_Q / 2, HALF_PI_Q, -HALF_PI_Q, PI_Q, -PI_Q,
                       TWO_PI_Q, -TWO_PI_Q, 3 * ONE_Q, -5 * ONE_Q, 7 * ONE_Q + ONE_Q / 2,
                       32'sh5555_5555, 32'shAAAA_AAAA};
    run_phase(10, 1'b0, 150, 1'b0);

    run_phase(0, 1'b1, 60, 1'b0);      // zero terms: result always zero
    run_phase(16, 1'b1, 100, 1'b0);    // full table
    run_phase(31, 1'b1, 60, 1'b0);     // above the cap: sums 16 terms
    run_phase(1, 1'b1, 80, 1'b1);      // back to back, no idling
    run_phase(2, 1'b1, 80, 1'b0);      // large angles clip here
    run_phase(5, 1'b1, 80, 1'b0);
    repeat (3) run_phase($urandom_range(0, 31), 1'b1, 50, 1'b0);

    // Catch any stray result after the last expected one.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && sine_expected.size() == 0) begin
      $display("tb_taylor_sine_series passed");
    end else begin
      $display("tb_taylor_sine_series failed");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/tss_pkg.sv
hw/rtl/tss_mul.sv
hw/rtl/taylor_sine_series.sv
test/tb_taylor_sine_series.sv
